### src/u8e_pkg.sv
// Shared types, constants and byte-forming functions of the UTF-8 encoder.
package u8e_pkg;

    localparam int QueueDepth = 4;

    localparam int CpW  = 31;
    localparam int LenW = 3;

    localparam logic [20:0] SuppBase = 21'h010000;
    localparam logic [15:0] SurrLo   = 16'hD800;
    localparam logic [15:0] SurrHi   = 16'hDFFF;

    localparam logic [CpW-1:0] Max1 = 31'h0000007F;
    localparam logic [CpW-1:0] Max2 = 31'h000007FF;
    localparam logic [CpW-1:0] Max3 = 31'h0000FFFF;
    localparam logic [CpW-1:0] Max4 = 31'h001FFFFF;
    localparam logic [CpW-1:0] Max5 = 31'h03FFFFFF;

    localparam logic [LenW-1:0] Len1 = 3'd1;
    localparam logic [LenW-1:0] Len2 = 3'd2;
    localparam logic [LenW-1:0] Len3 = 3'd3;
    localparam logic [LenW-1:0] Len4 = 3'd4;
    localparam logic [LenW-1:0] Len5 = 3'd5;
    localparam logic [LenW-1:0] Len6 = 3'd6;

    localparam logic [1:0] ContTag = 2'b10;

    typedef struct packed {
        logic [CpW-1:0]  cp;
        logic [LenW-1:0] len;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    function automatic logic [LenW-1:0] f_len(input logic [CpW-1:0] cp);
        logic [LenW-1:0] len;
        priority if (cp <= Max1) len = Len1;
        else if (cp <= Max2)     len = Len2;
        else if (cp <= Max3)     len = Len3;
        else if (cp <= Max4)     len = Len4;
        else if (cp <= Max5)     len = Len5;
        else                     len = Len6;
        return len;
    endfunction

    function automatic logic [7:0] f_lead(input logic [CpW-1:0] cp,
                                          input logic [LenW-1:0] len);
        logic [7:0] b;
        unique case (len)
            Len1:    b = {1'b0, cp[6:0]};
            Len2:    b = {3'b110, cp[10:6]};
            Len3:    b = {4'b1110, cp[15:12]};
            Len4:    b = {5'b11110, cp[20:18]};
            Len5:    b = {6'b111110, cp[25:24]};
            Len6:    b = {7'b1111110, cp[30]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // k counts continuation bytes still to follow this one
    function automatic logic [7:0] f_cont(input logic [CpW-1:0] cp,
                                          input logic [LenW-1:0] k);
        logic [35:0] w;
        logic [5:0]  s;
        w = {5'b0, cp};
        unique case (k)
            3'd0:    s = w[5:0];
            3'd1:    s = w[11:6];
            3'd2:    s = w[17:12];
            3'd3:    s = w[23:18];
            3'd4:    s = w[29:24];
            3'd5:    s = w[35:30];
            default: s = 6'h00;
        endcase
        return {ContTag, s};
    endfunction

endpackage

### src/u8e_front.sv
// Front end: mode register, surrogate pairing, code point and length classification.
module u8e_front
    import u8e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_code_value,
    input  logic        i_full,
    output t_push       o_push
);

    logic        r_utf16;
    logic [15:0] r_held;
    logic [15:0] n_held;
    logic        accept;
    logic [15:0] unit;
    logic        is_surr;
    logic [20:0] paired;
    logic [CpW-1:0] cp;
    logic        emit;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign unit    = i_code_value[15:0];
    assign is_surr = (unit >= SurrLo) && (unit <= SurrHi);
    assign paired  = {1'b0, r_held[9:0], unit[9:0]} + SuppBase;

    always_comb begin
        cp     = i_code_value;
        emit   = 1'b1;
        n_held = r_held;
        if (!r_utf16) begin
            n_held = 16'h0000;
        end else if (r_held != 16'h0000) begin
            cp     = CpW'(paired);
            n_held = 16'h0000;
        end else if (is_surr) begin
            // hold the leading unit, nothing goes out yet
            cp     = CpW'(unit);
            emit   = 1'b0;
            n_held = unit;
        end else begin
            cp = CpW'(unit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf16 <= 1'b1;
            r_held  <= 16'h0000;
        end else begin
            if (i_cfg_wr_en) begin
                r_utf16 <= i_cfg_wr_data;
            end
            if (accept) begin
                r_held <= n_held;
            end
        end
    end

    assign o_push.valid     = accept && emit;
    assign o_push.entry.cp  = cp;
    assign o_push.entry.len = f_len(cp);

endmodule

### src/u8e_queue.sv
// Short register queue between the front end and the byte serializer.
module u8e_queue
    import u8e_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    input  logic  i_pop,
    output t_head o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_full = (r_count == CW'(DEPTH));
    assign push   = i_push.valid && !o_full;
    assign pop    = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/u8e_back.sv
// Back end: queued code points to UTF-8 bytes, one per unstalled cycle, in an output register.
module u8e_back
    import u8e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_head      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    logic            r_valid;
    logic            n_valid;
    logic [7:0]      r_byte;
    logic [7:0]      n_byte;
    logic            r_last;
    logic            n_last;
    logic [CpW-1:0]  r_cp;
    logic [CpW-1:0]  n_cp;
    logic [LenW-1:0] r_rem;
    logic [LenW-1:0] n_rem;
    logic            out_free;

    assign out_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_cp    = r_cp;
        n_rem   = r_rem;
        o_pop   = 1'b0;
        if (out_free) begin
            if (r_rem != '0) begin
                n_valid = 1'b1;
                n_byte  = f_cont(r_cp, r_rem - 1'b1);
                n_last  = (r_rem == LenW'(1));
                n_rem   = r_rem - 1'b1;
            end else if (i_head.valid) begin
                // take the next request and send its lead byte
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_byte  = f_lead(i_head.entry.cp, i_head.entry.len);
                n_last  = (i_head.entry.len == Len1);
                n_cp    = i_head.entry.cp;
                n_rem   = i_head.entry.len - 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_cp   <= n_cp;
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

endmodule

### src/utf8_encoder_with_surrogates_unit.sv
// Top level of the UTF-8 encoder with UTF-16 surrogate pairing.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_code_value[30:0]
//   result    out        o_valid / i_ready   o_out_byte[7:0], o_last_byte
//   config    in         i_cfg_wr_en         i_cfg_wr_data
//
// The result side sends one byte per cycle while i_ready is high; a code
// point gives 1 to 6 bytes, and a held surrogate is taken at the input
// and sends nothing. The front end takes a request per cycle
// while the queue (QUEUE_DEPTH entries) has room.
// Synchronous active-low reset: mode back to UTF-16, no surrogate held,
// queue and output register empty. A stalled output register holds its byte.
module utf8_encoder_with_surrogates_unit
    import u8e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_code_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    u8e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_value (i_code_value),
        .i_full       (full),
        .o_push       (push)
    );

    u8e_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_pop  (pop),
        .o_head (head)
    );

    u8e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last_byte(o_last_byte)
    );

endmodule

### src/u8e_checker.sv
// Port-level checks of the UTF-8 encoder and their binding to the top level.
module u8e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_byte
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last_byte))
        else $error("result changed while stalled");

    a_cont_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_byte |=> o_valid && (o_out_byte[7:6] == 2'b10))
        else $error("continuation byte missing after non-final byte");

    a_ascii_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_byte[7] |-> o_last_byte)
        else $error("single-byte encoding not flagged last");

    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_byte[7:6] == 2'b11) |-> !o_last_byte)
        else $error("multi-byte lead flagged last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind utf8_encoder_with_surrogates_unit u8e_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_last_byte(o_last_byte)
);

### bench/tb_top.sv
// Testbench for the UTF-8 encoder: directed and random code values checked byte by byte.
`timescale 1ns / 100ps

module tb_top;

    typedef enum bit {
        MODE_UTF32 = 1'b0,
        MODE_UTF16 = 1'b1
    } t_mode;

    typedef struct {
        bit [7:0] data;
        bit       last;
    } t_utf8_byte;

    localparam int SettleCycles = 12;
    localparam int StallLimit   = 1000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [30:0] i_code_value  = '0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    t_utf8_byte  exp_bytes[$];
    t_mode       utf16_mode = MODE_UTF16;
    bit   [15:0] held_unit  = '0;
    bit          no_idle    = 1'b0;
    int          n_errors   = 0;
    int          stall_left = 0;
    int          calm_left  = 0;
    int          quiet_cycles = 0;

    utf8_encoder_with_surrogates_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_value  (i_code_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queue the UTF-8 bytes of one code point, lead byte first.
    function automatic void encode_utf8(bit [30:0] cp);
        int         n;
        int         sh;
        t_utf8_byte b;
        if (cp <= 31'h7F) begin
            n = 1;
            b.data = {1'b0, cp[6:0]};
        end else if (cp <= 31'h7FF) begin
            n = 2;
            b.data = 8'hC0 | 8'(cp[10:6]);
        end else if (cp <= 31'hFFFF) begin
            n = 3;
            b.data = 8'hE0 | 8'(cp[15:12]);
        end else if (cp <= 31'h1FFFFF) begin
            n = 4;
            b.data = 8'hF0 | 8'(cp[20:18]);
        end else if (cp <= 31'h3FFFFFF) begin
            n = 5;
            b.data = 8'hF8 | 8'(cp[25:24]);
        end else begin
            n = 6;
            b.data = 8'hFC | 8'(cp[30]);
        end
        b.last = (n == 1);
        exp_bytes.push_back(b);
        for (int i = 1; i < n; i++) begin
            sh = 6 * (n - 1 - i);
            b.data = 8'h80 | 8'((cp >> sh) & 31'h3F);
            b.last = (i == n - 1);
            exp_bytes.push_back(b);
        end
    endfunction

    function automatic void predict_step(bit [30:0] v);
        bit [15:0] unit;
        bit [20:0] cp;
        if (utf16_mode == MODE_UTF32) begin
            held_unit = '0;
            encode_utf8(v);
            return;
        end
        unit = v[15:0];
        if (held_unit != 0) begin
            // pair with whatever unit comes next, then drop the held one
            cp = {held_unit[9:0], unit[9:0]} + 21'h010000;
            held_unit = '0;
            encode_utf8(31'(cp));
        end else if (unit >= 16'hD800 && unit <= 16'hDFFF) begin
            held_unit = unit;
        end else begin
            encode_utf8(31'(unit));
        end
    endfunction

    // Receiver: random stall bursts between stretches of steady ready.
    always @(negedge i_clk) begin
        if (no_idle) begin
            i_ready = 1'b1;
        end else if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else if (calm_left > 0) begin
            i_ready = 1'b1;
            calm_left--;
        end else if ($urandom_range(0, 1) == 0) begin
            i_ready = 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            i_ready = 1'b1;
            calm_left = $urandom_range(1, 40);
        end
    end

    always @(posedge i_clk) begin
        t_utf8_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_bytes.size() == 0) begin
                $error("unexpected byte: out_byte %02h last_byte %0d", o_out_byte, o_last_byte);
                n_errors++;
            end else begin
                want = exp_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, actual %02h", want.data, o_out_byte);
                    n_errors++;
                end
                if (o_last_byte !== want.last) begin
                    $error("last_byte: expected %0d, actual %0d", want.last, o_last_byte);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or byte moving.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_code(input bit [30:0] v);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_code_value = v;
        do @(posedge i_clk); while (!o_ready);
        predict_step(v);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        while (exp_bytes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = m;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        utf16_mode = m;
    endtask

    function automatic bit [30:0] rand_code_point();
        case ($urandom_range(0, 6))
            0:       return 31'($urandom_range(0, 32'h7F));
            1:       return 31'($urandom_range(32'h80, 32'h7FF));
            2:       return 31'($urandom_range(32'h800, 32'hFFFF));
            3:       return 31'($urandom_range(32'h10000, 32'h1FFFFF));
            4:       return 31'($urandom_range(32'h200000, 32'h3FFFFFF));
            5:       return 31'($urandom_range(32'h4000000, 32'h7FFFFFFF));
            default: return 31'($urandom);
        endcase
    endfunction

    // Mostly well-formed pairs and BMP units, some lone surrogates and wide noise.
    task automatic send_random_utf16(output int sent);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                send_code(31'(16'hD800 | 16'($urandom_range(0, 16'h3FF))));
                send_code(31'(16'hDC00 | 16'($urandom_range(0, 16'h3FF))));
                sent = 2;
            end
            5, 6: begin
                send_code(rand_code_point() & 31'hFFFF);
                sent = 1;
            end
            7: begin
                send_code(31'($urandom));
                sent = 1;
            end
            8: begin
                send_code(31'(16'hD800 | 16'($urandom_range(0, 16'h3FF))));
                send_code(31'($urandom));
                sent = 2;
            end
            default: begin
                send_code(31'(16'hDC00 | 16'($urandom_range(0, 16'h3FF))));
                sent = 1;
            end
        endcase
    endtask

    task automatic test_utf16_basic();
        send_code(31'h00);
        send_code(31'h7F);
        send_code(31'h80);
        send_code(31'h7FF);
        send_code(31'h800);
        send_code(31'hFFFF);
        // upper bits are ignored in UTF-16 mode
        send_code(31'h7FFF0041);
        wait_idle(SettleCycles);
    endtask

    task automatic test_surrogate_pairing();
        send_code(31'hD83D);
        send_code(31'hDE00);
        send_code(31'hDBFF);
        send_code(31'hDFFF);
        send_code(31'hD800);
        send_code(31'h0041);
        send_code(31'hDC00);
        send_code(31'hDBFF);
        wait_idle(SettleCycles);
    endtask

    task automatic test_held_across_mode_change();
        send_code(31'hD900);
        wait_idle(SettleCycles);
        set_mode(MODE_UTF32);
        set_mode(MODE_UTF16);
        send_code(31'hDC01);
        send_code(31'hD800);
        wait_idle(SettleCycles);
        set_mode(MODE_UTF32);
        send_code(31'h41);
        wait_idle(SettleCycles);
        set_mode(MODE_UTF16);
        send_code(31'h42);
        wait_idle(SettleCycles);
    endtask

    task automatic test_utf32_lengths();
        set_mode(MODE_UTF32);
        send_code(31'h10000);
        send_code(31'h1FFFFF);
        send_code(31'h200000);
        send_code(31'h3FFFFFF);
        send_code(31'h4000000);
        send_code(31'h7FFFFFFF);
        send_code(31'hD800);
        wait_idle(SettleCycles);
    endtask

    task automatic test_random_utf16();
        int total;
        int sent;
        set_mode(MODE_UTF16);
        total = 0;
        while (total < 150) begin
            send_random_utf16(sent);
            total += sent;
            // hold off until every byte has drained while the sent total is 60 or 61
            if (total >= 60 && total < 62) wait_idle(0);
        end
        wait_idle(SettleCycles);
    endtask

    task automatic test_random_utf32();
        set_mode(MODE_UTF32);
        repeat (120) send_code(rand_code_point());
        wait_idle(SettleCycles);
    endtask

    task automatic test_random_mixed();
        int total;
        int sent;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3) no_idle = 1'b1;
            if (phase % 2 == 0) begin
                set_mode(MODE_UTF32);
                repeat (20) send_code(rand_code_point());
            end else begin
                set_mode(MODE_UTF16);
                total = 0;
                while (total < 20) begin
                    send_random_utf16(sent);
                    total += sent;
                end
            end
            wait_idle(SettleCycles);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_utf16_basic();
        test_surrogate_pairing();
        test_held_across_mode_change();
        test_utf32_lengths();
        test_random_utf16();
        test_random_utf32();
        test_random_mixed();
        wait_idle(SettleCycles);
        if (n_errors == 0 && exp_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
